// ===== rtl/tsmr_pkg.sv =====
// ----------------------------------------------------------------------------
// tsmr_pkg: shared types and constants for time_scale_muldiv_round
// widths, status codes, divider stage record and one restoring divide step
// ----------------------------------------------------------------------------
package tsmr_pkg;

  localparam int DATA_W     = 64;
  localparam int HALF_W     = DATA_W / 2;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int TIME_WIDTH = 64;  // 32..64, width of time and of the result limit
  localparam int DIV_STEPS  = DATA_W;

  localparam logic [DATA_W-1:0] TW_MASK = {DATA_W{1'b1}} >> (DATA_W - TIME_WIDTH);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_UNIT = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  // one divider stage: partial remainder, dividend bits shifting out while
  // quotient bits shift in, the divisor and the early status
  typedef struct packed {
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] lq;
    logic [DATA_W-1:0] unit;
    status_t           st;
  } div_t;

  function automatic div_t div_step(input div_t s);
    div_t        o;
    logic [DATA_W:0] sh;
    logic [DATA_W:0] diff;
    o    = s;
    // shifted remainder including the bit that falls off the top
    sh   = {s.rem, s.lq[DATA_W-1]};
    diff = sh - {1'b0, s.unit};
    if (!diff[DATA_W]) begin
      o.rem = diff[DATA_W-1:0];
      o.lq  = {s.lq[DATA_W-2:0], 1'b1};
    end else begin
      o.rem = sh[DATA_W-1:0];
      o.lq  = {s.lq[DATA_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// ===== rtl/tsmr_mul.sv =====
// ----------------------------------------------------------------------------
// tsmr_mul: two-stage 64x64 -> 128 unsigned multiplier
// four 32x32 partial products in the first stage, summed in the second
// ----------------------------------------------------------------------------
module tsmr_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [tsmr_pkg::DATA_W-1:0] a,
  input  logic [tsmr_pkg::DATA_W-1:0] b,
  input  logic [tsmr_pkg::DATA_W-1:0] unit_in,
  output logic                        vld,
  output logic [tsmr_pkg::PROD_W-1:0] prod,
  output logic [tsmr_pkg::DATA_W-1:0] unit_out
);
  import tsmr_pkg::*;

  logic              v1_r, v2_r;
  logic [DATA_W-1:0] ll_r, hl_r, lh_r, hh_r;
  logic [DATA_W-1:0] unit1_r, unit2_r;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r    <= a[HALF_W-1:0]      * b[HALF_W-1:0];
      hl_r    <= a[DATA_W-1:HALF_W] * b[HALF_W-1:0];
      lh_r    <= a[HALF_W-1:0]      * b[DATA_W-1:HALF_W];
      hh_r    <= a[DATA_W-1:HALF_W] * b[DATA_W-1:HALF_W];
      unit1_r <= unit_in;
      unit2_r <= unit1_r;
      prod_r  <= prod_nxt;
    end
  end

  always_comb begin
    prod_nxt = {hh_r, ll_r}
             + (PROD_W'(hl_r) << HALF_W)
             + (PROD_W'(lh_r) << HALF_W);
  end

  assign vld      = v2_r;
  assign prod     = prod_r;
  assign unit_out = unit2_r;

endmodule

// ===== rtl/tsmr_div.sv =====
// ----------------------------------------------------------------------------
// tsmr_div: pipelined restoring 128/64 divider, one quotient bit per stage
// also classifies zero divisor and quotient overflow on entry
// ----------------------------------------------------------------------------
module tsmr_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [tsmr_pkg::PROD_W-1:0] prod,
  input  logic [tsmr_pkg::DATA_W-1:0] unit_in,
  output logic                        vld,
  output tsmr_pkg::div_t              res
);
  import tsmr_pkg::*;

  div_t               init;
  div_t               step_nxt [DIV_STEPS];
  div_t               stage_r  [DIV_STEPS];
  logic [DIV_STEPS-1:0] vld_r;

  // early status: zero divisor first, then a high half that is too big
  always_comb begin
    init.rem  = prod[PROD_W-1:DATA_W];
    init.lq   = prod[DATA_W-1:0];
    init.unit = unit_in;
    if (unit_in == '0) begin
      init.st = ST_ZERO_UNIT;
    end else if (prod[PROD_W-1:DATA_W] >= unit_in) begin
      init.st = ST_OVERFLOW;
    end else begin
      init.st = ST_OK;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    if (k == 0) begin : g_first
      assign step_nxt[k] = div_step(init);
    end else begin : g_rest
      assign step_nxt[k] = div_step(stage_r[k-1]);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stage_r[k] <= step_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_STEPS-2:0], in_vld};
    end
  end

  assign vld = vld_r[DIV_STEPS-1];
  assign res = stage_r[DIV_STEPS-1];

endmodule

// ===== rtl/time_scale_muldiv_round.sv =====
// ----------------------------------------------------------------------------
// time_scale_muldiv_round: scale a simulation time to a target unit
// (time * precision) / unit, rounded half up, with error status
// ----------------------------------------------------------------------------
// Each request carries a current time and a time unit in femtoseconds. The
// block forms the 128-bit product of the time and the design precision
// register, divides it by the unit and rounds the quotient half up (one is
// added when twice the remainder reaches the unit). Errors never stall the
// block: status 1 flags a zero unit, status 2 a quotient or rounded result
// that does not fit in TIME_WIDTH bits, and in both cases scaled_time is 0.
// Requests are independent, so a new one is taken every cycle while in_stall
// is low. A result passes 67 register stages: two multiplier stages (four
// 32x32 partial products, then the 128-bit sum), 64 restoring divider stages
// at one quotient bit each, and the head entry of a two-entry output register
// pair, which the rounding step feeds combinationally.
// in_stall rises only when both output entries are full, so a result
// waiting on out_stall does not hold off new requests until then.
// The precision register resets to 1 and is written through cfg_wr_en and
// cfg_wr_data; write it only while no request is in flight.
// ----------------------------------------------------------------------------
module time_scale_muldiv_round (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [tsmr_pkg::DATA_W-1:0] cfg_wr_data,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tsmr_pkg::DATA_W-1:0] in_current_time,
  input  logic [tsmr_pkg::DATA_W-1:0] in_time_unit,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tsmr_pkg::DATA_W-1:0] out_scaled_time,
  output logic [1:0]                  out_status
);
  import tsmr_pkg::*;

  logic [DATA_W-1:0] design_precision_r;

  logic              en;
  logic              mul_vld;
  logic [PROD_W-1:0] mul_prod;
  logic [DATA_W-1:0] mul_unit;
  logic              div_vld;
  div_t              div_res;

  // rounding result
  logic [DATA_W-1:0] rnd_q;
  status_t           rnd_st;
  logic              rnd_up;
  logic              push;
  logic              pop;

  // output entry pair: head drives the ports, skid catches one more
  logic              head_v_r, skid_v_r;
  logic [DATA_W-1:0] head_q_r, skid_q_r;
  status_t           head_st_r, skid_st_r;

  // precision register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      design_precision_r <= DATA_W'(1);
    end else if (cfg_wr_en) begin
      design_precision_r <= cfg_wr_data;
    end
  end

  // whole pipeline moves while the skid entry is free
  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  tsmr_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .a        (in_current_time & TW_MASK),
    .b        (design_precision_r),
    .unit_in  (in_time_unit),
    .vld      (mul_vld),
    .prod     (mul_prod),
    .unit_out (mul_unit)
  );

  tsmr_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (mul_vld),
    .prod    (mul_prod),
    .unit_in (mul_unit),
    .vld     (div_vld),
    .res     (div_res)
  );

  // round half up: 2*rem >= unit, guarded against the result limit
  always_comb begin
    rnd_up = {div_res.rem, 1'b0} >= {1'b0, div_res.unit};
    rnd_q  = '0;
    rnd_st = div_res.st;
    if (div_res.st == ST_OK) begin
      if ((div_res.lq & ~TW_MASK) != '0) begin
        rnd_st = ST_OVERFLOW;
      end else if (rnd_up && (div_res.lq == TW_MASK)) begin
        rnd_st = ST_OVERFLOW;
      end else begin
        rnd_q = div_res.lq + DATA_W'(rnd_up);
      end
    end
  end

  assign push = en && div_vld;
  assign pop  = head_v_r && !out_stall;

  // output entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (pop || !head_v_r) begin
      head_v_r <= skid_v_r || push;
      skid_v_r <= skid_v_r && push;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !head_v_r) begin
      if (skid_v_r) begin
        head_q_r  <= skid_q_r;
        head_st_r <= skid_st_r;
        skid_q_r  <= rnd_q;
        skid_st_r <= rnd_st;
      end else begin
        head_q_r  <= rnd_q;
        head_st_r <= rnd_st;
      end
    end else if (push) begin
      skid_q_r  <= rnd_q;
      skid_st_r <= rnd_st;
    end
  end

  assign out_valid       = head_v_r;
  assign out_scaled_time = head_q_r;
  assign out_status      = head_st_r;

endmodule
